FILE: sv/emst_pkg.sv
// shared types and constants for the extent map section translator
// table geometry, action and status codes, entry and memory request structs
package emst_pkg;

  localparam int PARTITIONS  = 512;
  localparam int MINOR_LIMIT = 512;
  localparam int FRAGMENTS   = 1024;

  localparam int PIDX_W = $clog2(PARTITIONS);
  localparam int FIDX_W = $clog2(FRAGMENTS);
  localparam int FCNT_W = FIDX_W + 1;

  localparam logic [1:0] ACT_WR_PART = 2'd0;
  localparam logic [1:0] ACT_WR_EXT  = 2'd1;
  localparam logic [1:0] ACT_XLATE   = 2'd2;
  localparam logic [1:0] ACT_LOOKUP  = 2'd3;

  localparam logic [1:0] STS_WDONE = 2'd0;
  localparam logic [1:0] STS_FOUND = 2'd1;
  localparam logic [1:0] STS_MISS  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PCHK,
    ST_ECHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [9:0]  tag;
    logic [9:0]  first;
    logic [15:0] count;
  } part_ent_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } ext_ent_t;

  typedef struct packed {
    logic              we;
    logic [PIDX_W-1:0] waddr;
    part_ent_t         wdata;
    logic              re;
    logic [PIDX_W-1:0] raddr;
  } pmem_req_t;

  typedef struct packed {
    logic              we;
    logic [FIDX_W-1:0] waddr;
    ext_ent_t          wdata;
    logic              re;
    logic [FIDX_W-1:0] raddr;
  } emem_req_t;

endpackage

FILE: sv/emst_part_mem.sv
// partition table: tag, first fragment and fragment count per partition
// one write and one registered read port; uses emst_pkg
module emst_part_mem
  import emst_pkg::*;
(
  input  logic      clk,
  input  pmem_req_t req,
  output part_ent_t rdata
);

  part_ent_t mem [PARTITIONS];
  part_ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/emst_ext_mem.sv
// fragment table: first section and length per extent slot
// one write and one registered read port; uses emst_pkg
module emst_ext_mem
  import emst_pkg::*;
(
  input  logic      clk,
  input  emem_req_t req,
  output ext_ent_t  rdata
);

  ext_ent_t mem [FRAGMENTS];
  ext_ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/extent_map_section_translator.sv
// Extent map section translator. The input channel (in_*) carries one word per
// action: partition write, fragment write, translate or owner lookup. The output
// channel (out_*) returns exactly one word (status, value) per input word, in order.
// Both channels use valid/stall; a word moves when valid is high and stall is low.
// Items are handled one at a time; in_stall is high while an item is in progress.
// A write goes from acceptance to the done state, and its result enters the output
// register as soon as that register is free. A translate reads its partition entry,
// checks it, then walks its extents; a minor out of range goes straight to done, and
// a tag mismatch or an empty partition ends after the partition check. A lookup
// reads each partition entry in turn and walks its extents, so it grows with the partition count.
// The next word is taken in the cycle after a result is loaded.
// The walk is set by the extent memory read port, one entry per cycle.
// A finished result sits in the output register while the next item is accepted;
// a stalled receiver only holds the sequencer when a second result is ready.
// After reset the partition table is cleared one entry per cycle, with in_stall
// high; fragment slots are not cleared.
// Uses emst_pkg, emst_part_mem and emst_ext_mem.
module extent_map_section_translator
  import emst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [9:0]  in_minor,
  input  logic [9:0]  in_tag,
  input  logic [9:0]  in_fragment_index,
  input  logic [15:0] in_fragment_count,
  input  logic [31:0] in_section,
  input  logic [31:0] in_extent_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_value
);

  state_t state_r, state_nxt;

  logic [PIDX_W-1:0] clr_r, clr_nxt;
  logic              xlate_r, xlate_nxt;
  logic [31:0]       sect_r, sect_nxt;
  logic [9:0]        minor_r, minor_nxt;
  logic [PIDX_W-1:0] p_r, p_nxt;
  logic [31:0]       base_r, base_nxt;
  logic [FIDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [31:0]       res_value_r, res_value_nxt;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_value_r;

  pmem_req_t pmem_req;
  emem_req_t emem_req;
  part_ent_t pd;
  ext_ent_t  ed;

  emst_part_mem u_part_mem (
    .clk   (clk),
    .req   (pmem_req),
    .rdata (pd)
  );

  emst_ext_mem u_ext_mem (
    .clk   (clk),
    .req   (emem_req),
    .rdata (ed)
  );

  logic              in_acc;
  logic              out_free;
  logic              minor_bad;
  logic              p_empty;
  logic              tag_bad;
  logic              p_last;
  logic [32:0]       ext_sum;
  logic              e_below;
  logic              e_hit;
  logic [FCNT_W-1:0] idx_inc;
  logic              e_last;
  logic [PIDX_W-1:0] p_inc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign minor_bad = ({1'b0, in_minor} >= 11'(MINOR_LIMIT)) ||
                     ({1'b0, in_minor} >= 11'(PARTITIONS));
  assign p_empty   = (pd.count == 16'd0) || ({1'b0, pd.first} >= 11'(FRAGMENTS));
  assign tag_bad   = (pd.tag != minor_r);
  assign p_last    = (p_r == PIDX_W'(PARTITIONS - 1));
  assign p_inc     = p_r + PIDX_W'(1);

  // translate adds the running offset, lookup adds the extent start
  assign ext_sum = {1'b0, (xlate_r ? base_r : ed.start)} + {1'b0, ed.size};
  assign e_below = !xlate_r && (sect_r < ed.start);
  assign e_hit   = !e_below && ({1'b0, sect_r} < ext_sum);
  assign idx_inc = {1'b0, idx_r} + FCNT_W'(1);
  // offset past 2^32 can never be reached by a 32-bit section
  assign e_last  = (rem_r == 16'd1) || (idx_inc >= FCNT_W'(FRAGMENTS)) ||
                   (xlate_r && ext_sum[32]) || e_below;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == PIDX_W'(PARTITIONS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_action)
            ACT_XLATE:  state_nxt = minor_bad ? ST_DONE : ST_PCHK;
            ACT_LOOKUP: state_nxt = ST_PCHK;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PCHK: begin
        if (xlate_r) begin
          state_nxt = (tag_bad || p_empty) ? ST_DONE : ST_ECHK;
        end else if (p_empty) begin
          state_nxt = p_last ? ST_DONE : ST_PCHK;
        end else begin
          state_nxt = ST_ECHK;
        end
      end
      ST_ECHK: begin
        if (e_hit) begin
          state_nxt = ST_DONE;
        end else if (e_last) begin
          state_nxt = (xlate_r || p_last) ? ST_DONE : ST_PCHK;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    clr_nxt        = clr_r;
    xlate_nxt      = xlate_r;
    sect_nxt       = sect_r;
    minor_nxt      = minor_r;
    p_nxt          = p_r;
    base_nxt       = base_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;

    pmem_req       = '0;
    emem_req       = '0;

    case (state_r)
      ST_CLEAR: begin
        pmem_req.we    = 1'b1;
        pmem_req.waddr = clr_r;
        clr_nxt        = clr_r + PIDX_W'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          xlate_nxt      = (in_action == ACT_XLATE);
          sect_nxt       = in_section;
          minor_nxt      = in_minor;
          p_nxt          = '0;
          res_status_nxt = STS_MISS;
          res_value_nxt  = 32'd0;
          case (in_action)
            ACT_WR_PART: begin
              res_status_nxt = STS_WDONE;
              if ({1'b0, in_minor} < 11'(PARTITIONS)) begin
                pmem_req.we          = 1'b1;
                pmem_req.waddr       = in_minor[PIDX_W-1:0];
                pmem_req.wdata.tag   = in_tag;
                pmem_req.wdata.first = in_fragment_index;
                pmem_req.wdata.count = in_fragment_count;
              end
            end
            ACT_WR_EXT: begin
              res_status_nxt = STS_WDONE;
              if ({1'b0, in_fragment_index} < 11'(FRAGMENTS)) begin
                emem_req.we          = 1'b1;
                emem_req.waddr       = in_fragment_index[FIDX_W-1:0];
                emem_req.wdata.start = in_section;
                emem_req.wdata.size  = in_extent_length;
              end
            end
            ACT_XLATE: begin
              pmem_req.re    = 1'b1;
              pmem_req.raddr = in_minor[PIDX_W-1:0];
            end
            default: begin
              pmem_req.re    = 1'b1;
              pmem_req.raddr = '0;
            end
          endcase
        end
      end
      ST_PCHK: begin
        if ((xlate_r && !tag_bad && !p_empty) || (!xlate_r && !p_empty)) begin
          // start the extent walk of this partition
          emem_req.re    = 1'b1;
          emem_req.raddr = pd.first[FIDX_W-1:0];
          idx_nxt        = pd.first[FIDX_W-1:0];
          rem_nxt        = pd.count;
          base_nxt       = 32'd0;
        end else if (!xlate_r && !p_last) begin
          pmem_req.re    = 1'b1;
          pmem_req.raddr = p_inc;
          p_nxt          = p_inc;
        end
      end
      ST_ECHK: begin
        if (e_hit) begin
          res_status_nxt = STS_FOUND;
          if (xlate_r) begin
            res_value_nxt = ed.start + (sect_r - base_r);
          end else begin
            res_value_nxt = 32'(p_r);
          end
        end else if (e_last) begin
          if (!xlate_r && !p_last) begin
            pmem_req.re    = 1'b1;
            pmem_req.raddr = p_inc;
            p_nxt          = p_inc;
          end
        end else begin
          emem_req.re    = 1'b1;
          emem_req.raddr = idx_inc[FIDX_W-1:0];
          idx_nxt        = idx_inc[FIDX_W-1:0];
          rem_nxt        = rem_r - 16'd1;
          base_nxt       = ext_sum[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    xlate_r      <= xlate_nxt;
    sect_r       <= sect_nxt;
    minor_r      <= minor_nxt;
    p_r          <= p_nxt;
    base_r       <= base_nxt;
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

FILE: tb/sv/tb.sv
// testbench for extent_map_section_translator: directed table and walk cases, then random traffic
// predicts every response word from its own copy of the partition and fragment tables
// depends on emst_pkg and the translator rtl
module tb;
  import emst_pkg::*;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  minor;
    logic [9:0]  tag;
    logic [9:0]  fragment_index;
    logic [15:0] fragment_count;
    logic [31:0] section;
    logic [31:0] extent_length;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } resp_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [9:0]  in_minor = '0;
  logic [9:0]  in_tag = '0;
  logic [9:0]  in_fragment_index = '0;
  logic [15:0] in_fragment_count = '0;
  logic [31:0] in_section = '0;
  logic [31:0] in_extent_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_value;

  extent_map_section_translator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_minor          (in_minor),
    .in_tag            (in_tag),
    .in_fragment_index (in_fragment_index),
    .in_fragment_count (in_fragment_count),
    .in_section        (in_section),
    .in_extent_length  (in_extent_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_value         (out_value)
  );

  // shadow copy of the block's tables
  logic [9:0]  part_tag   [PARTITIONS];
  logic [9:0]  part_first [PARTITIONS];
  logic [15:0] part_count [PARTITIONS];
  logic [31:0] ext_start  [FRAGMENTS];
  logic [31:0] ext_len    [FRAGMENTS];
  bit          slot_loaded[FRAGMENTS];

  resp_t pending_results[$];
  int    mismatches = 0;
  int    words_sent = 0;
  bit    quiet = 1'b0;
  int    hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < PARTITIONS; i++) begin
      part_tag[i] = '0;
      part_first[i] = '0;
      part_count[i] = '0;
    end
    for (int i = 0; i < FRAGMENTS; i++) begin
      ext_start[i] = '0;
      ext_len[i] = '0;
      slot_loaded[i] = 1'b0;
    end
  end

  function automatic cmd_t make_cmd(input logic [1:0] action, input logic [9:0] minor, tag, fidx,
                                    input logic [15:0] fcnt, input logic [31:0] sect, elen);
    cmd_t c;
    c.action = action;
    c.minor = minor;
    c.tag = tag;
    c.fragment_index = fidx;
    c.fragment_count = fcnt;
    c.section = sect;
    c.extent_length = elen;
    return c;
  endfunction

  // applies one accepted word to the shadow tables and returns its response
  function automatic resp_t predict_response(input cmd_t c);
    resp_t r;
    longint unsigned sect64;
    longint unsigned base;
    longint unsigned lim;
    int unsigned idx;
    int unsigned k;
    bit hit;
    r.status = STS_WDONE;
    r.value = '0;
    sect64 = {32'd0, c.section};
    hit = 1'b0;
    case (c.action)
      ACT_WR_PART: begin
        if (c.minor < PARTITIONS) begin
          part_tag[c.minor] = c.tag;
          part_first[c.minor] = c.fragment_index;
          part_count[c.minor] = c.fragment_count;
        end
      end
      ACT_WR_EXT: begin
        if (c.fragment_index < FRAGMENTS) begin
          ext_start[c.fragment_index] = c.section;
          ext_len[c.fragment_index] = c.extent_length;
          slot_loaded[c.fragment_index] = 1'b1;
        end
      end
      ACT_XLATE: begin
        r.status = STS_MISS;
        if (c.minor < MINOR_LIMIT && c.minor < PARTITIONS && part_tag[c.minor] == c.minor &&
            part_count[c.minor] != 0) begin
          base = 0;
          for (k = 0; k < part_count[c.minor]; k++) begin
            idx = part_first[c.minor] + k;
            if (idx >= FRAGMENTS) break;
            lim = base + {32'd0, ext_len[idx]};
            if (sect64 < lim) begin
              r.status = STS_FOUND;
              r.value = 32'({32'd0, ext_start[idx]} + (sect64 - base));
              break;
            end
            base = lim;
          end
        end
      end
      ACT_LOOKUP: begin
        r.status = STS_MISS;
        for (int p = 0; p < PARTITIONS && !hit; p++) begin
          for (k = 0; k < part_count[p]; k++) begin
            idx = part_first[p] + k;
            if (idx >= FRAGMENTS) break;
            if (c.section < ext_start[idx]) break;
            lim = {32'd0, ext_start[idx]};
            lim += {32'd0, ext_len[idx]};
            if (sect64 < lim) begin
              r.status = STS_FOUND;
              r.value = 32'(p);
              hit = 1'b1;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // offers one word, with an occasional idle gap first, and waits for its acceptance
  task automatic send_word(input cmd_t c);
    int gap;
    if (!quiet && $urandom_range(99) < 10) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= c.action;
    in_minor <= c.minor;
    in_tag <= c.tag;
    in_fragment_index <= c.fragment_index;
    in_fragment_count <= c.fragment_count;
    in_section <= c.section;
    in_extent_length <= c.extent_length;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(predict_response(c));
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %0s at %0t: expected %h, got %h", what, $time, want, got);
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 10);
      end
    end
  end

  always @(posedge clk) begin : check_out
    resp_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word", '0, {30'b0, out_status});
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", {30'b0, want.status}, {30'b0, out_status});
        if (out_value !== want.value) flag_mismatch("value", want.value, out_value);
      end
    end
  end

  task automatic test_empty_table();
    send_word(make_cmd(ACT_XLATE, 10'd0, 10'd0, 10'd0, 16'd0, 32'd0, 32'd0));
    send_word(make_cmd(ACT_LOOKUP, 10'd0, 10'd0, 10'd0, 16'd0, 32'hffffffff, 32'd0));
  endtask

  task automatic test_translate_cases();
    send_word(make_cmd(ACT_WR_EXT, 10'd0, 10'd0, 10'd0, 16'd0, 32'd1000, 32'd10));
    // zero-length extent holds no section
    send_word(make_cmd(ACT_WR_EXT, 10'd0, 10'd0, 10'd1, 16'd0, 32'd5000, 32'd0));
    // physical section wraps, extent end does not
    send_word(make_cmd(ACT_WR_EXT, 10'd0, 10'd0, 10'd2, 16'd0, 32'hfffffff0, 32'hffffffff));
    send_word(make_cmd(ACT_WR_PART, 10'd5, 10'd5, 10'd0, 16'd3, 32'd0, 32'd0));
    send_word(make_cmd(ACT_XLATE, 10'd5, 10'd0, 10'd0, 16'd0, 32'd0, 32'd0));
    send_word(make_cmd(ACT_XLATE, 10'd5, 10'd0, 10'd0, 16'd0, 32'd10, 32'd0));
    send_word(make_cmd(ACT_XLATE, 10'd5, 10'd0, 10'd0, 16'd0, 32'hffffffff, 32'd0));
    // stored tag differs from the minor
    send_word(make_cmd(ACT_WR_PART, 10'd6, 10'd7, 10'd0, 16'd1, 32'd0, 32'd0));
    send_word(make_cmd(ACT_XLATE, 10'd6, 10'd0, 10'd0, 16'd0, 32'd0, 32'd0));
    send_word(make_cmd(ACT_XLATE, 10'd512, 10'd0, 10'd0, 16'd0, 32'd0, 32'd0));
    // section just past the last extent
    send_word(make_cmd(ACT_WR_PART, 10'd9, 10'd9, 10'd0, 16'd2, 32'd0, 32'd0));
    send_word(make_cmd(ACT_XLATE, 10'd9, 10'd0, 10'd0, 16'd0, 32'd10, 32'd0));
  endtask

  task automatic test_lookup_cases();
    send_word(make_cmd(ACT_WR_EXT, 10'd0, 10'd0, 10'd1023, 16'd0, 32'd50, 32'd5));
    send_word(make_cmd(ACT_WR_EXT, 10'd0, 10'd0, 10'd3, 16'd0, 32'd8000, 32'd10));
    send_word(make_cmd(ACT_WR_EXT, 10'd0, 10'd0, 10'd4, 16'd0, 32'd100, 32'd100));
    // walk runs off the end of the fragment table
    send_word(make_cmd(ACT_WR_PART, 10'd7, 10'd7, 10'd1023, 16'hffff, 32'd0, 32'd0));
    send_word(make_cmd(ACT_WR_PART, 10'd8, 10'd8, 10'd3, 16'd2, 32'd0, 32'd0));
    send_word(make_cmd(ACT_XLATE, 10'd7, 10'd0, 10'd0, 16'd0, 32'd3, 32'd0));
    send_word(make_cmd(ACT_XLATE, 10'd7, 10'd0, 10'd0, 16'd0, 32'd100, 32'd0));
    send_word(make_cmd(ACT_LOOKUP, 10'd0, 10'd0, 10'd0, 16'd0, 32'd52, 32'd0));
    send_word(make_cmd(ACT_LOOKUP, 10'd0, 10'd0, 10'd0, 16'd0, 32'hffffffff, 32'd0));
    // partition 8 holds 150 in its second extent but its walk stops at the first
    send_word(make_cmd(ACT_LOOKUP, 10'd0, 10'd0, 10'd0, 16'd0, 32'd150, 32'd0));
  endtask

  task automatic test_ignored_writes();
    send_word(make_cmd(ACT_WR_PART, 10'd600, 10'h3ff, 10'h3ff, 16'hffff, 32'hffffffff,
                       32'hffffffff));
    send_word(make_cmd(ACT_XLATE, 10'd600, 10'd0, 10'd0, 16'd0, 32'd0, 32'd0));
  endtask

  // receiver holds off long enough that the block backs up into its input
  task automatic test_backpressure();
    hold_request = 300;
    repeat (12) begin
      if ($urandom_range(1))
        send_word(make_cmd(ACT_WR_EXT, 10'($urandom), 10'($urandom), 10'($urandom),
                           16'($urandom), $urandom, $urandom));
      else
        send_word(make_cmd(ACT_XLATE, 10'($urandom), 10'($urandom), 10'($urandom),
                           16'($urandom), $urandom, $urandom));
    end
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n, input bit no_idle);
    int stop;
    int k;
    int f;
    int p;
    int j;
    logic [31:0] st[16];
    logic [31:0] ln[16];
    logic [31:0] sect;
    logic [9:0] mn;
    longint unsigned total;
    cmd_t c;
    quiet = no_idle;
    stop = words_sent + n;
    while (words_sent < stop) begin
      if ($urandom_range(9) < 7) begin
        // well-formed: load extents, point a partition at them, then query
        k = ($urandom_range(9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        f = $urandom_range(FRAGMENTS - k);
        p = $urandom_range(PARTITIONS - 1);
        total = 0;
        for (j = 0; j < k; j++) begin
          case ($urandom_range(9))
            0: ln[j] = '0;
            1: ln[j] = $urandom;
            default: ln[j] = $urandom_range(1, 4096);
          endcase
          if (j == 0 || $urandom_range(3) == 0) st[j] = $urandom;
          else st[j] = st[j-1] + ln[j-1] + $urandom_range(0, 64);
          total += {32'd0, ln[j]};
          send_word(make_cmd(ACT_WR_EXT, 10'($urandom), 10'($urandom), 10'(f + j),
                             16'($urandom), st[j], ln[j]));
        end
        send_word(make_cmd(ACT_WR_PART, 10'(p), ($urandom_range(9) == 0) ? 10'($urandom) : 10'(p),
                           10'(f), ($urandom_range(19) == 0) ? 16'd0 : 16'(k), $urandom,
                           $urandom));
        repeat ($urandom_range(2, 4)) begin
          case ($urandom_range(9))
            0: sect = total[31:0];
            1: sect = 32'(total - 1);
            2: sect = $urandom;
            default: sect = (total == 0) ? $urandom : 32'({$urandom, $urandom} % total);
          endcase
          mn = ($urandom_range(9) == 0) ? 10'($urandom) : 10'(p);
          send_word(make_cmd(ACT_XLATE, mn, 10'($urandom), 10'($urandom), 16'($urandom), sect,
                             $urandom));
        end
        if ($urandom_range(3) == 0) begin
          j = $urandom_range(k - 1);
          sect = (ln[j] == 0) ? st[j] : st[j] + $urandom_range(ln[j] - 1);
          send_word(make_cmd(ACT_LOOKUP, 10'($urandom), 10'($urandom), 10'($urandom),
                             16'($urandom), sect, $urandom));
        end
      end else begin
        c = make_cmd(2'($urandom), 10'($urandom), 10'($urandom), 10'($urandom), 16'($urandom),
                     $urandom, $urandom);
        case (c.action)
          ACT_WR_PART: begin
            if ($urandom_range(3) != 0) c.fragment_count = 16'($urandom_range(8));
            // long extent lists only near the table end, so lookups stay short
            if (c.minor < PARTITIONS && c.fragment_count > 8)
              c.fragment_index = 10'($urandom_range(FRAGMENTS - 16, FRAGMENTS - 1));
            if (c.minor < PARTITIONS) begin
              for (j = int'(c.fragment_index);
                   j < int'(c.fragment_index) + int'(c.fragment_count) && j < FRAGMENTS;
                   j++) begin
                if (!slot_loaded[j])
                  send_word(make_cmd(ACT_WR_EXT, 10'($urandom), 10'($urandom), 10'(j),
                                     16'($urandom), $urandom, $urandom_range(0, 4096)));
              end
            end
          end
          ACT_XLATE: begin
            if ($urandom_range(1)) c.minor = 10'($urandom_range(PARTITIONS - 1));
          end
          ACT_LOOKUP: begin
            j = $urandom_range(FRAGMENTS - 1);
            if ($urandom_range(1) && slot_loaded[j]) c.section = ext_start[j] + $urandom_range(3);
          end
          default: ;
        endcase
        send_word(c);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_translate_cases();
    test_lookup_cases();
    test_ignored_writes();
    test_backpressure();
    test_random_traffic(1150, 1'b0);
    test_random_traffic(200, 1'b1);
    wait_idle();
    repeat (64) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #60000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
